[src/erm_pkg.sv]
package erm_pkg;

   // Default resolution of the angle table and of the fixed-point results.
   localparam int AngleBitsDefault    = 12;
   localparam int FractionBitsDefault = 12;

   // Field widths fixed by the stream format.
   localparam int FieldWidth    = 16;
   localparam int AngleCount    = 3;
   localparam int MatrixEntries = 9;
   localparam int ReqWidth      = AngleCount * FieldWidth;
   localparam int RspWidth      = MatrixEntries * FieldWidth;
   localparam int RomWordWidth  = 2 * FieldWidth;

   // Number of terms of the sine series used to build the table.
   localparam int SeriesTerms = 14;

   // pi/2 in Q2.62.
   localparam longint unsigned HalfPiQ62 = 64'h6487_ED51_10B4_611A;

   typedef logic [MatrixEntries-1:0][FieldWidth-1:0] matrix_type;

   // Load enables of the two lane stages.
   typedef struct packed {
      logic load_rom;
      logic load_trig;
   } lane_ctl_type;

   // Load enables of the three merge stages.
   typedef struct packed {
      logic load_prod;
      logic load_cross;
      logic load_out;
   } merge_ctl_type;

   // (a*b) >> 62 for a and b below 2^63, kept to 64 bits.
   function automatic longint unsigned mul_q62(input longint unsigned a,
                                               input longint unsigned b);
      longint unsigned ah, al, bh, bl, lo, m1, m2, hi, t, low64, high;
      ah    = a >> 32;
      al    = a & 64'h0000_0000_FFFF_FFFF;
      bh    = b >> 32;
      bl    = b & 64'h0000_0000_FFFF_FFFF;
      lo    = al * bl;
      m1    = ah * bl;
      m2    = al * bh;
      hi    = ah * bh;
      t     = (lo >> 32) + (m1 & 64'h0000_0000_FFFF_FFFF) + (m2 & 64'h0000_0000_FFFF_FFFF);
      low64 = (lo & 64'h0000_0000_FFFF_FFFF) | (t << 32);
      high  = hi + (m1 >> 32) + (m2 >> 32) + (t >> 32);
      return (high << 2) | (low64 >> 62);
   endfunction

   // Divides a series term by (2n)(2n+1).
   function automatic longint unsigned series_div(input longint unsigned term, input int n);
      case (n)
         1:       return term / 64'd6;
         2:       return term / 64'd20;
         3:       return term / 64'd42;
         4:       return term / 64'd72;
         5:       return term / 64'd110;
         6:       return term / 64'd156;
         7:       return term / 64'd210;
         8:       return term / 64'd272;
         9:       return term / 64'd342;
         10:      return term / 64'd420;
         11:      return term / 64'd506;
         12:      return term / 64'd600;
         13:      return term / 64'd702;
         14:      return term / 64'd812;
         default: return term;
      endcase
   endfunction

   // Rounded sine over the first quarter turn, k steps out of 2^qbits.
   function automatic int quarter_sine(input int unsigned k, input int qbits, input int fbits);
      longint unsigned f, x, x2, term, sum;
      f    = 64'(k) << (62 - qbits);
      x    = mul_q62(HalfPiQ62, f);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= SeriesTerms; n++) begin
         term = series_div(mul_q62(term, x2), n);
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return int'((sum + (64'd1 << (61 - fbits))) >> (62 - fbits));
   endfunction

   // Rounded sine over the full turn of 2^abits steps.
   function automatic int full_sine(input int unsigned i, input int abits, input int fbits);
      int unsigned qbits, quarter, q, k;
      int v;
      qbits   = abits - 2;
      quarter = 1 << qbits;
      q       = (i >> qbits) & 3;
      k       = i & (quarter - 1);
      v       = ((q & 1) != 0) ? quarter_sine(quarter - k, qbits, fbits)
                               : quarter_sine(k, qbits, fbits);
      return ((q & 2) != 0) ? -v : v;
   endfunction

   // One table word: cosine in the upper half, sine in the lower half.
   function automatic logic [RomWordWidth-1:0] rom_word(input int unsigned i,
                                                         input int abits,
                                                         input int fbits);
      int unsigned mask, quarter;
      int sn, cs;
      mask    = (1 << abits) - 1;
      quarter = 1 << (abits - 2);
      sn      = full_sine(i, abits, fbits);
      cs      = full_sine((i + quarter) & mask, abits, fbits);
      return {FieldWidth'(cs), FieldWidth'(sn)};
   endfunction

endpackage

[src/erm_lane.sv]
// One angle lane: table lookup of cosine and sine, then the sine takes the angle's sign.
module erm_lane #(
   parameter int ANGLE_BITS    = erm_pkg::AngleBitsDefault,
   parameter int FRACTION_BITS = erm_pkg::FractionBitsDefault
) (
   input  logic                                clock,
   input  erm_pkg::lane_ctl_type               ctl,
   input  logic signed [erm_pkg::FieldWidth-1:0] angle,
   output logic signed [erm_pkg::FieldWidth-1:0] cos_val,
   output logic signed [erm_pkg::FieldWidth-1:0] sin_val
);

   localparam int Fw       = erm_pkg::FieldWidth;
   localparam int Ww       = erm_pkg::RomWordWidth;
   localparam int RomDepth = 1 << ANGLE_BITS;

   // Constant cosine and sine table, one word per angle step, each word worked out
   // on its own while the design is elaborated.
   logic [Ww-1:0] trig_rom [RomDepth];

   for (genvar i = 0; i < RomDepth; i++) begin : g_rom
      localparam logic [Ww-1:0] Word = erm_pkg::rom_word(i, ANGLE_BITS, FRACTION_BITS);
      assign trig_rom[i] = Word;
   end

   logic [Fw-1:0]         magnitude;
   logic [ANGLE_BITS-1:0] index;
   logic [Ww-1:0]         word_ff;
   logic                  neg_ff;
   logic signed [Fw-1:0]  cos_in, sin_in, cos_ff, sin_ff;

   // The most negative angle wraps to itself, and its low bits index entry zero.
   assign magnitude = angle[Fw-1] ? Fw'((~angle) + 1'b1) : angle;
   assign index     = magnitude[ANGLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load_rom) begin
         word_ff <= trig_rom[index];
         neg_ff  <= angle[Fw-1];
      end
   end

   assign cos_in = $signed(word_ff[Ww-1:Fw]);
   assign sin_in = neg_ff ? -$signed(word_ff[Fw-1:0]) : $signed(word_ff[Fw-1:0]);

   always_ff @(posedge clock) begin
      if (ctl.load_trig) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

[src/erm_merge.sv]
// Combines the three lanes into the nine matrix entries over three stages.
module erm_merge #(
   parameter int FRACTION_BITS = erm_pkg::FractionBitsDefault
) (
   input  logic                                  clock,
   input  erm_pkg::merge_ctl_type                ctl,
   input  logic signed [erm_pkg::FieldWidth-1:0] cos_a,
   input  logic signed [erm_pkg::FieldWidth-1:0] sin_a,
   input  logic signed [erm_pkg::FieldWidth-1:0] cos_b,
   input  logic signed [erm_pkg::FieldWidth-1:0] sin_b,
   input  logic signed [erm_pkg::FieldWidth-1:0] cos_c,
   input  logic signed [erm_pkg::FieldWidth-1:0] sin_c,
   output erm_pkg::matrix_type                   matrix
);

   localparam int Fw = erm_pkg::FieldWidth;

   // Fixed-point product; the arithmetic shift rounds toward minus infinity.
   function automatic logic signed [Fw-1:0] fmul(input logic signed [Fw-1:0] x,
                                                 input logic signed [Fw-1:0] y);
      logic signed [2*Fw-1:0] p;
      p = (2*Fw)'(x) * (2*Fw)'(y);
      return Fw'(p >>> FRACTION_BITS);
   endfunction

   // First products. r and s are sinB*sinA and cosB*sinA, reused below.
   logic signed [Fw-1:0] r_ff, s_ff, cc_ff, sc_ff;
   logic signed [Fw-1:0] cbcc_ff, cbsc_ff, sbca_ff, scca_ff, ccca_ff;
   logic signed [Fw-1:0] sbcc_ff, sbsc_ff, cbca_ff, nsa_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         r_ff    <= fmul(sin_b, sin_a);
         s_ff    <= fmul(cos_b, sin_a);
         cc_ff   <= cos_c;
         sc_ff   <= sin_c;
         cbcc_ff <= fmul(cos_b, cos_c);
         cbsc_ff <= fmul(cos_b, sin_c);
         sbca_ff <= fmul(sin_b, cos_a);
         scca_ff <= fmul(sin_c, cos_a);
         ccca_ff <= fmul(cos_c, cos_a);
         sbcc_ff <= fmul(sin_b, cos_c);
         sbsc_ff <= fmul(sin_b, sin_c);
         cbca_ff <= fmul(cos_b, cos_a);
         nsa_ff  <= -sin_a;
      end
   end

   // Second products; each entry is held as two addends.
   erm_pkg::matrix_type ta_ff, tb_ff, out_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_cross) begin
         ta_ff[0] <= cbcc_ff;
         tb_ff[0] <= fmul(r_ff, sc_ff);
         ta_ff[1] <= -cbsc_ff;
         tb_ff[1] <= fmul(r_ff, cc_ff);
         ta_ff[2] <= sbca_ff;
         tb_ff[2] <= '0;
         ta_ff[3] <= scca_ff;
         tb_ff[3] <= '0;
         ta_ff[4] <= ccca_ff;
         tb_ff[4] <= '0;
         ta_ff[5] <= nsa_ff;
         tb_ff[5] <= '0;
         ta_ff[6] <= -sbcc_ff;
         tb_ff[6] <= fmul(s_ff, sc_ff);
         ta_ff[7] <= sbsc_ff;
         tb_ff[7] <= fmul(s_ff, cc_ff);
         ta_ff[8] <= cbca_ff;
         tb_ff[8] <= '0;
      end
   end

   // Sums wrap to the entry width.
   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         for (int j = 0; j < erm_pkg::MatrixEntries; j++) begin
            out_ff[j] <= ta_ff[j] + tb_ff[j];
         end
      end
   end

   assign matrix = out_ff;

endmodule

[src/euler_angles_to_rotation_matrix_core.sv]
// An accepted beat moves through the table word, signed cosine and sine, first product,
// second product and result registers, then its matrix is on rsp_. One angle triple per
// cycle while rsp_tready is high; five pipeline stages, one table read per lane. While
// the result beat waits, earlier stages keep accepting until the pipeline is full.
// Reset is synchronous and active high; it clears every stage valid bit, and req_tready
// is held low while reset is asserted. Payload registers are not reset.
module euler_angles_to_rotation_matrix_core #(
   parameter int ANGLE_BITS    = erm_pkg::AngleBitsDefault,
   parameter int FRACTION_BITS = erm_pkg::FractionBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input beat.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0 up: angle_a, angle_b, angle_c (16 bits each, signed).
   input  logic [erm_pkg::ReqWidth-1:0]  req_tdata,
   // Result beat.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0 up: row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
   // row1_col2, row2_col0, row2_col1, row2_col2 (16 bits each, signed, 4.12).
   output logic [erm_pkg::RspWidth-1:0]  rsp_tdata
);

   localparam int Fw     = erm_pkg::FieldWidth;
   localparam int Stages = 5;

   // Stage valid bits. Stage 0 holds the table words, stage 1 the signed cosine
   // and sine of each lane, stages 2 and 3 the products, stage 4 the result beat.
   logic [Stages-1:0] valid_ff, valid_in;
   logic [Stages-1:0] stage_en;
   logic              req_accept;

   // A stage loads when it is empty or when the stage after it moves on. A bubble
   // therefore closes up instead of stalling the whole pipeline.
   always_comb begin
      stage_en[Stages-1] = !valid_ff[Stages-1] || rsp_tready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_tready = stage_en[0] && !reset;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_accept;
      end
      for (int k = 1; k < Stages; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Three lanes, one per angle, side by side.
   logic signed [Fw-1:0] angle   [erm_pkg::AngleCount];
   logic signed [Fw-1:0] cos_val [erm_pkg::AngleCount];
   logic signed [Fw-1:0] sin_val [erm_pkg::AngleCount];
   erm_pkg::lane_ctl_type  lane_ctl;
   erm_pkg::merge_ctl_type merge_ctl;

   assign lane_ctl.load_rom   = stage_en[0];
   assign lane_ctl.load_trig  = stage_en[1];
   assign merge_ctl.load_prod  = stage_en[2];
   assign merge_ctl.load_cross = stage_en[3];
   assign merge_ctl.load_out   = stage_en[4];

   for (genvar g = 0; g < erm_pkg::AngleCount; g++) begin : g_lane
      assign angle[g] = $signed(req_tdata[g*Fw +: Fw]);

      erm_lane #(
         .ANGLE_BITS   (ANGLE_BITS),
         .FRACTION_BITS(FRACTION_BITS)
      ) u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .angle  (angle[g]),
         .cos_val(cos_val[g]),
         .sin_val(sin_val[g])
      );
   end

   // The merge stages form the products and the sums of the nine entries.
   erm_pkg::matrix_type matrix;

   erm_merge #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_merge (
      .clock (clock),
      .ctl   (merge_ctl),
      .cos_a (cos_val[0]),
      .sin_a (sin_val[0]),
      .cos_b (cos_val[1]),
      .sin_b (sin_val[1]),
      .cos_c (cos_val[2]),
      .sin_c (sin_val[2]),
      .matrix(matrix)
   );

   assign rsp_tvalid = valid_ff[Stages-1];
   assign rsp_tdata  = matrix;

endmodule

[src/erm_checker.sv]
module erm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [erm_pkg::RspWidth-1:0] rsp_tdata
);

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // With no result beat waiting, the block takes input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !reset |-> req_tready)
      else $error("input stalled while the output is empty");

   // A new result beat traces back to an accepted input beat, looking back the pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 5))
      else $error("result beat without a matching input beat");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

endmodule

bind euler_angles_to_rotation_matrix_core erm_checker u_erm_checker (.*);

[tb/sv/euler_angles_to_rotation_matrix_core_tb.sv]
`timescale 1ns / 1ps

module euler_angles_to_rotation_matrix_core_tb;

   // The block runs at its default resolution: 4096 angle steps per turn and
   // 12 fraction bits in every matrix entry.
   localparam int AngleBits    = 12;
   localparam int FractionBits = 12;
   localparam int QuarterBits  = AngleBits - 2;
   localparam int Quarter      = 1 << QuarterBits;
   localparam int TableDepth   = 1 << AngleBits;
   localparam int AngleMask    = TableDepth - 1;

   // pi/2 in Q2.62, the seed of the sine series.
   localparam logic [63:0] HalfPiQ62 = 64'h6487_ED51_10B4_611A;

   // The result pipeline is five stages deep; this many quiet cycles at the end
   // leave room for any stray beat to show up.
   localparam int SettleCycles = 12;

   // Length of the long result hold-off, in cycles.
   localparam int HoldOffCycles = 300;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   // Fields from bit 0 up: angle_a, angle_b, angle_c (16 bits each, signed).
   logic [erm_pkg::ReqWidth-1:0]     req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // Fields from bit 0 up: row0_col0 ... row2_col2 (16 bits each, signed, 4.12).
   logic [erm_pkg::RspWidth-1:0]     rsp_tdata;

   // Our own copy of the cosine and sine table, built at time zero.
   logic signed [15:0] cos_table [TableDepth];
   logic signed [15:0] sin_table [TableDepth];

   // Matrices still owed by the block, oldest first, with the angles that
   // produced them so that a mismatch can be traced back to its input beat.
   erm_pkg::matrix_type                expected_matrices [$];
   logic [erm_pkg::ReqWidth-1:0]       expected_angles   [$];

   int  mismatch_count;
   int  triples_sent;
   int  matrices_checked;
   int  stall_cycles;

   // Traffic shaping knobs for the sender and the receiver.
   bit  sender_idles;
   bit  receiver_idles;
   int  hold_seq;
   int  hold_len;

   euler_angles_to_rotation_matrix_core #(
      .ANGLE_BITS    (AngleBits),
      .FRACTION_BITS (FractionBits)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A hung pipeline must not stall the run forever. The slowest legal run is
   // well under two milliseconds, so twenty leaves a wide margin.
   initial begin
      #20_000_000;
      $display("Timeout: the block stopped delivering matrices.");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Table generation. The sine is a Taylor series evaluated in Q2.62 over the
   // first quarter turn and rounded to the fraction width; the other quarters
   // follow by symmetry, and the cosine is the sine a quarter turn ahead.
   // ------------------------------------------------------------------------

   // Upper product bits: (x*y) >> 62, kept to 64 bits.
   function automatic logic [63:0] q62_mul(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return p[125:62];
   endfunction

   function automatic int quarter_wave(input int unsigned k);
      logic [63:0] x, x2, term, sum;
      x    = q62_mul(HalfPiQ62, 64'(k) << (62 - QuarterBits));
      x2   = q62_mul(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 14; n++) begin
         term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return int'((sum + (64'd1 << (61 - FractionBits))) >> (62 - FractionBits));
   endfunction

   function automatic int sine_at(input int unsigned i);
      int unsigned q, k;
      int v;
      q = (i >> QuarterBits) & 3;
      k = i & (Quarter - 1);
      v = ((q & 1) != 0) ? quarter_wave(Quarter - k) : quarter_wave(k);
      return ((q & 2) != 0) ? -v : v;
   endfunction

   // ------------------------------------------------------------------------
   // Matrix prediction.
   // ------------------------------------------------------------------------

   // The table is indexed by the magnitude of the angle, so -32768 lands on
   // entry 0 and anything past one turn wraps through the mask. A negative
   // angle keeps its cosine and flips its sine.
   function automatic void angle_to_trig(input logic signed [15:0] ang,
                                         output longint c, output longint s);
      int mag;
      mag = ang;
      if (mag < 0) begin
         mag = -mag;
      end
      mag = mag & AngleMask;
      c = cos_table[mag];
      s = sin_table[mag];
      if (ang < 0) begin
         s = -s;
      end
   endfunction

   // An arithmetic shift floors negative products toward minus infinity.
   function automatic longint scaled_product(input longint x, input longint y);
      return (x * y) >>> FractionBits;
   endfunction

   function automatic erm_pkg::matrix_type predict_rotation(
         input logic [erm_pkg::ReqWidth-1:0] angles);
      longint ca, sa, cb, sb, cc, sc, ba, bc;
      erm_pkg::matrix_type m;
      angle_to_trig(angles[15:0],  ca, sa);
      angle_to_trig(angles[31:16], cb, sb);
      angle_to_trig(angles[47:32], cc, sc);
      // sinB*sinA feeds row zero and cosB*sinA feeds row two; each is formed once.
      ba   = scaled_product(sb, sa);
      bc   = scaled_product(cb, sa);
      m[0] = 16'(scaled_product(cb, cc) + scaled_product(ba, sc));
      m[1] = 16'(-scaled_product(cb, sc) + scaled_product(ba, cc));
      m[2] = 16'(scaled_product(sb, ca));
      m[3] = 16'(scaled_product(sc, ca));
      m[4] = 16'(scaled_product(cc, ca));
      m[5] = 16'(-sa);
      m[6] = 16'(-scaled_product(sb, cc) + scaled_product(bc, sc));
      m[7] = 16'(scaled_product(sb, sc) + scaled_product(bc, cc));
      m[8] = 16'(scaled_product(cb, ca));
      return m;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Most angles use all sixteen bits; the rest stay within one turn or sit on
   // or one step beside a quarter-turn boundary, where sine and cosine hit 0 and 1.
   function automatic logic [15:0] pick_angle();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (r < 70) begin
         return 16'($urandom());
      end else if (r < 85) begin
         return 16'(int'($urandom_range(8190, 0)) - 4095);
      end else begin
         return 16'(int'($urandom_range(63, 0)) * 1024 + int'($urandom_range(2, 0)) - 1);
      end
   endfunction

   // Sends one angle triple and records its matrix once the beat is taken.
   // Valid is dropped only when a gap follows, so back-to-back beats never see
   // valid lowered and raised in the same step. Data is scrambled while idle.
   task automatic send_triple(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c);
      int gap;
      int unsigned r;
      gap = 0;
      if (sender_idles) begin
         r = $urandom_range(99, 0);
         if (r >= 92) begin
            gap = $urandom_range(40, 8);
         end else if (r >= 60) begin
            gap = $urandom_range(3, 1);
         end
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 48'({$urandom(), $urandom()});
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_matrices.push_back(predict_rotation({c, b, a}));
      expected_angles.push_back({c, b, a});
      triples_sent++;
   endtask

   // Stops offering beats and waits until every matrix owed has come out.
   task automatic wait_for_all_matrices();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_matrices.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Hand-picked angles: zero, quarter, half and three-quarter turns on each
   // axis, the most negative angle (which folds onto table entry 0), the
   // largest positive one, angles past one turn, small negative angles whose
   // products floor away from zero, and alternating bit patterns.
   task automatic test_corner_angles();
      sender_idles   = 1;
      receiver_idles = 1;
      send_triple(16'sd0,      16'sd0,      16'sd0);
      send_triple(16'sd1024,   16'sd0,      16'sd0);
      send_triple(16'sd0,      16'sd1024,   16'sd0);
      send_triple(16'sd0,      16'sd0,      16'sd1024);
      send_triple(16'sd2048,   16'sd2048,   16'sd2048);
      send_triple(16'sd3072,   -16'sd1024,  16'sd1024);
      send_triple(16'h8000,    16'h8000,    16'h8000);
      send_triple(16'h7FFF,    16'h7FFF,    16'h7FFF);
      send_triple(-16'sd32767, 16'h7FFF,    -16'sd1);
      send_triple(16'sd1,      -16'sd1,     16'sd1);
      send_triple(16'sd4095,   -16'sd4095,  16'sd4096);
      send_triple(-16'sd4096,  16'sd4097,   -16'sd4097);
      send_triple(16'sd512,    -16'sd512,   16'sd341);
      send_triple(-16'sd1,     -16'sd2,     -16'sd3);
      send_triple(16'h7FFF,    16'h8000,    16'h0000);
      send_triple(16'h5555,    16'hAAAA,    16'h0F0F);
      send_triple(16'hAAAA,    16'h5555,    16'hF0F0);
      send_triple(-16'sd100,   16'sd200,    -16'sd300);
      send_triple(16'sd12288,  -16'sd12288, 16'sd8191);
      wait_for_all_matrices();
   endtask

   // Random angles with random gaps on both sides of the block.
   task automatic test_random_idling(input int count);
      sender_idles   = 1;
      receiver_idles = 1;
      repeat (count) send_triple(pick_angle(), pick_angle(), pick_angle());
   endtask

   // One beat per cycle in and out: the pipeline must sustain full rate.
   task automatic test_full_rate(input int count);
      sender_idles   = 0;
      receiver_idles = 0;
      repeat (count) send_triple(pick_angle(), pick_angle(), pick_angle());
      sender_idles   = 1;
      receiver_idles = 1;
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the pipeline fills and req_tready has to drop.
   task automatic test_result_hold_off(input int count);
      wait_for_all_matrices();
      sender_idles = 0;
      hold_len     = HoldOffCycles;
      hold_seq++;
      repeat (count) send_triple(pick_angle(), pick_angle(), pick_angle());
      sender_idles = 1;
   endtask

   // Short bursts, each followed by a full drain of the pipeline, so that the
   // block goes empty and restarts from idle many times.
   task automatic test_burst_then_drain(input int bursts);
      repeat (bursts) begin
         repeat ($urandom_range(12, 1)) send_triple(pick_angle(), pick_angle(), pick_angle());
         wait_for_all_matrices();
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: drives rsp_tready. A hold-off request is counted out here, in
   // cycles; otherwise the ready line is either always high or toggles with
   // mostly short and occasionally long gaps.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int seen_hold;
      int low_cycles;
      seen_hold  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen_hold) begin
            seen_hold  = hold_seq;
            rsp_tready <= 1'b0;
            repeat (hold_len - 1) @(posedge clock);
         end else if (receiver_idles && ($urandom_range(99, 0) < 30)) begin
            low_cycles = ($urandom_range(9, 0) < 8) ? $urandom_range(3, 1)
                                                    : $urandom_range(40, 10);
            rsp_tready <= 1'b0;
            repeat (low_cycles - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: every result beat is compared, entry by entry, with the
   // oldest matrix still owed. Signals are sampled as they stood just before
   // the clock edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_checker
      erm_pkg::matrix_type          want;
      erm_pkg::matrix_type          got;
      logic [erm_pkg::ReqWidth-1:0] angles;
      if (!reset) begin
         if (req_tvalid && !req_tready) begin
            stall_cycles++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_matrices.size() == 0) begin
               $display("%0t: result beat with no matrix owed, actual %h", $time, got);
               mismatch_count++;
            end else begin
               want   = expected_matrices.pop_front();
               angles = expected_angles.pop_front();
               matrices_checked++;
               for (int j = 0; j < erm_pkg::MatrixEntries; j++) begin
                  if (got[j] !== want[j]) begin
                     $display("%0t: row%0d_col%0d for angles %0d %0d %0d: expected %0d, actual %0d",
                              $time, j / 3, j % 3, $signed(angles[15:0]),
                              $signed(angles[31:16]), $signed(angles[47:32]),
                              $signed(want[j]), $signed(got[j]));
                     mismatch_count++;
                  end
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      for (int i = 0; i < TableDepth; i++) begin
         sin_table[i] = 16'(sine_at(i));
         cos_table[i] = 16'(sine_at((i + Quarter) & AngleMask));
      end

      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      sender_idles     = 1;
      receiver_idles   = 1;
      hold_seq         = 0;
      hold_len         = 0;
      mismatch_count   = 0;
      triples_sent     = 0;
      matrices_checked = 0;
      stall_cycles     = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_corner_angles();
      test_random_idling(400);
      test_full_rate(200);
      test_result_hold_off(60);
      test_burst_then_drain(23);
      test_random_idling(220);

      // Drain, then give the pipeline time to emit anything it should not.
      wait_for_all_matrices();
      repeat (SettleCycles) @(posedge clock);

      $display("Ran %0d angle triples: corners, idling on both sides, full rate, a %0d-cycle",
               triples_sent, HoldOffCycles);
      $display("result hold-off and burst drains; %0d matrices checked, input stalled %0d cycles.",
               matrices_checked, stall_cycles);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
